FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define EMVL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("emvl check failed");

// Next-cycle implication, checked on every rising edge outside reset
`define EMVL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("emvl check failed");

`endif

FILE: rtl/emvl_pkg.sv
// Types, constants and routing tables for the multivector linear map
package emvl_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BLADE  = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  localparam int NUM_BLADES = 16;
  localparam int NUM_DIAG   = 5;   // slices 0..4
  localparam int NUM_LOW    = 4;   // slices 5..8
  localparam logic [3:0] FIRST_LOW_SLICE = 4'd5;
  localparam logic [3:0] NUM_SLICES      = 4'd9;
  localparam logic [3:0] LAST_BLADE      = 4'd15;

  typedef logic signed [39:0] acc_t;
  typedef logic signed [31:0] prod_val_t;
  typedef logic signed [15:0] q312_t;

  localparam acc_t ACC_MAX = {1'b0, {39{1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {39{1'b0}}};

  // Accepted input transaction
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] index;
    q312_t      value;
  } item_t;

  // Product stage contents handed to the accumulators
  typedef struct packed {
    logic      is_finish;
    logic [3:0] diag_dest;
    logic       low_en;
    logic [3:0] low_dest;
    prod_val_t  p_diag;
    prod_val_t  p_low;
    q312_t      bias;
  } prod_t;

  // Grade-lowering route of one source blade
  typedef struct packed {
    logic       en;
    logic [3:0] dest;
    logic [1:0] bank;   // slice minus 5
  } low_route_t;

  // Unsigned Q1.16 slice norm, 1.0 as 65536
  function automatic logic [16:0] slice_scale(logic [3:0] slice);
    logic [16:0] s;
    case (slice)
      4'd1, 4'd3: s = 17'd32768;
      4'd2:       s = 17'd26755;
      4'd6, 4'd7: s = 17'd37837;
      default:    s = 17'd65536;
    endcase
    return s;
  endfunction

  // Grade-diagonal slice, 0..4
  function automatic logic [2:0] diag_slice(logic [3:0] blade);
    logic [2:0] s;
    case (blade)
      4'd0:                         s = 3'd0;
      4'd1, 4'd2, 4'd3, 4'd4:       s = 3'd1;
      4'd11, 4'd12, 4'd13, 4'd14:   s = 3'd3;
      4'd15:                        s = 3'd4;
      default:                      s = 3'd2;
    endcase
    return s;
  endfunction

  function automatic low_route_t low_route(logic [3:0] blade);
    low_route_t r;
    case (blade)
      4'd0:    r = '{en: 1'b1, dest: 4'd1,  bank: 2'd0};
      4'd2:    r = '{en: 1'b1, dest: 4'd5,  bank: 2'd1};
      4'd3:    r = '{en: 1'b1, dest: 4'd6,  bank: 2'd1};
      4'd4:    r = '{en: 1'b1, dest: 4'd7,  bank: 2'd1};
      4'd8:    r = '{en: 1'b1, dest: 4'd11, bank: 2'd2};
      4'd9:    r = '{en: 1'b1, dest: 4'd12, bank: 2'd2};
      4'd10:   r = '{en: 1'b1, dest: 4'd13, bank: 2'd2};
      4'd14:   r = '{en: 1'b1, dest: 4'd15, bank: 2'd3};
      default: r = '{en: 1'b0, dest: 4'd0,  bank: 2'd0};
    endcase
    return r;
  endfunction

  // 40-bit accumulate with clamping
  function automatic acc_t sat_add(acc_t a, prod_val_t b);
    logic signed [40:0] s;
    acc_t r;
    s = 41'(a) + 41'(b);
    if (s[40] != s[39]) begin
      r = s[40] ? ACC_MIN : ACC_MAX;
    end else begin
      r = s[39:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/emvl_in_if.sv
// Input channel: action, index and value with valid/ready
interface emvl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         index;
  logic signed [15:0] value;

  modport source (output valid, action, index, value, input ready);
  modport sink   (input valid, action, index, value, output ready);
endinterface

FILE: rtl/emvl_out_if.sv
// Output channel: blade results with valid/ready
interface emvl_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         blade;
  logic signed [39:0] result_value;
  logic               last;

  modport source (output valid, blade, result_value, last, input ready);
  modport sink   (input valid, blade, result_value, last, output ready);
endinterface

FILE: rtl/emvl_mult.sv
// Slice weight store, weight scaling and blade product stage
module emvl_mult import emvl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  item_t in_item,
  output logic  p_valid,
  output prod_t prod
);

  q312_t diag_w [NUM_DIAG];
  q312_t low_w  [NUM_LOW];

  logic signed [33:0] wprod;
  logic signed [33:0] wsum;
  q312_t              wscaled;
  logic [2:0]         dsel;
  low_route_t         lroute;
  logic               is_load;
  logic               is_blade;
  logic               is_finish;
  prod_t              prod_next;

  assign is_load   = in_valid && (in_item.action == ACT_LOAD);
  assign is_blade  = in_valid && (in_item.action == ACT_BLADE);
  assign is_finish = in_valid && (in_item.action == ACT_FINISH);

  // Weight pre-scale, rounding half up
  assign wprod   = $signed(in_item.value) * $signed({1'b0, slice_scale(in_item.index)});
  assign wsum    = wprod + 34'sd32768;
  assign wscaled = wsum[31:16];

  // Weight banks: diagonal slices 0..4, lowering slices 5..8
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_DIAG; k++) diag_w[k] <= '0;
      for (int k = 0; k < NUM_LOW; k++)  low_w[k]  <= '0;
    end else if (adv && is_load) begin
      if (in_item.index < FIRST_LOW_SLICE) begin
        diag_w[in_item.index[2:0]] <= wscaled;
      end else if (in_item.index < NUM_SLICES) begin
        low_w[2'(in_item.index - FIRST_LOW_SLICE)] <= wscaled;
      end
    end
  end

  // Blade products
  assign dsel   = diag_slice(in_item.index);
  assign lroute = low_route(in_item.index);

  always_comb begin
    prod_next.is_finish = is_finish;
    prod_next.diag_dest = in_item.index;
    prod_next.low_en    = lroute.en;
    prod_next.low_dest  = lroute.dest;
    prod_next.p_diag    = diag_w[dsel] * in_item.value;
    prod_next.p_low     = low_w[lroute.bank] * in_item.value;
    prod_next.bias      = in_item.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= is_blade || is_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= prod_next;
    end
  end

endmodule

FILE: rtl/emvl_acc.sv
// Per-blade saturating accumulators and finish snapshot
module emvl_acc import emvl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  p_valid,
  input  prod_t prod,
  output acc_t  snap [NUM_BLADES]
);

  acc_t      acc [NUM_BLADES];
  prod_val_t bias_q;

  // Bias moved to Q7.24
  assign bias_q = {{4{prod.bias[15]}}, prod.bias, 12'd0};

  // Snapshot seen by the output buffer, bias folded into blade 0
  always_comb begin
    for (int k = 0; k < NUM_BLADES; k++) snap[k] = acc[k];
    snap[0] = sat_add(acc[0], bias_q);
  end

  // One accumulator cell per blade; the two paths never hit the same blade
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BLADES; k++) acc[k] <= '0;
    end else if (adv && p_valid) begin
      for (int k = 0; k < NUM_BLADES; k++) begin
        if (prod.is_finish) begin
          acc[k] <= '0;
        end else if (prod.diag_dest == 4'(k)) begin
          acc[k] <= sat_add(acc[k], prod.p_diag);
        end else if (prod.low_en && prod.low_dest == 4'(k)) begin
          acc[k] <= sat_add(acc[k], prod.p_low);
        end
      end
    end
  end

endmodule

FILE: rtl/emvl_obuf.sv
// Result buffer streaming 16 blades per finish
module emvl_obuf import emvl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  acc_t  snap [NUM_BLADES],
  output logic  free,
  emvl_out_if.source result
);

  acc_t       rbuf [NUM_BLADES];
  logic       busy;
  logic [3:0] cnt;
  logic       take;

  assign take = result.valid && result.ready;
  assign free = !busy || (take && cnt == LAST_BLADE);

  // Stream control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (take) begin
      cnt <= cnt + 4'd1;
      if (cnt == LAST_BLADE) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NUM_BLADES; k++) rbuf[k] <= snap[k];
    end
  end

  assign result.valid        = busy;
  assign result.blade        = cnt;
  assign result.result_value = rbuf[cnt];
  assign result.last         = (cnt == LAST_BLADE);

endmodule

FILE: rtl/equivariant_multivector_linear.sv
// Flow: a finish transaction passes the input register and the product register, then
// loads the result buffer, which returns one blade result per cycle while result.ready is high.
// Throughput: one transaction per cycle; a finish waits in the product stage
// while the previous 16 results are still being drained.
// Reset (rst, synchronous) clears weights, accumulators and all valid flags.
module equivariant_multivector_linear import emvl_pkg::*; (
  input  logic clk,
  input  logic rst,
  emvl_in_if.sink    item,
  emvl_out_if.source result
);

  logic  in_valid;
  item_t in_item;
  logic  p_valid;
  prod_t prod;
  logic  free;
  logic  adv;
  logic  load;
  acc_t  snap [NUM_BLADES];

  // Whole pipeline steps unless a finish meets a busy result buffer
  assign adv        = !(p_valid && prod.is_finish && !free);
  assign load       = adv && p_valid && prod.is_finish;
  assign item.ready = adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (adv) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item.valid) begin
      in_item <= '{action: item.action, index: item.index, value: item.value};
    end
  end

  emvl_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_valid(in_valid),
    .in_item (in_item),
    .p_valid (p_valid),
    .prod    (prod)
  );

  emvl_acc u_acc (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .p_valid(p_valid),
    .prod   (prod),
    .snap   (snap)
  );

  emvl_obuf u_obuf (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .snap  (snap),
    .free  (free),
    .result(result)
  );

endmodule

FILE: rtl/emvl_checker.sv
// Port-level checks on the result stream, bound to the top level
`include "assert_macros.svh"

module emvl_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [3:0]  result_blade,
  input logic [39:0] result_value,
  input logic        result_last
);

  // Stalled result holds
  `EMVL_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result_blade) && $stable(result_value))

  // Blades of one run come back to back in ascending order
  `EMVL_ASSERT_NEXT(a_seq, result_valid && result_ready && !result_last, result_valid && result_blade == $past(result_blade) + 4'd1)

  // Last flag marks blade 15 only
  `EMVL_ASSERT_NOW(a_last, result_valid, result_last == (result_blade == 4'd15))

  // A run starts at blade 0
  `EMVL_ASSERT_NEXT(a_start, !result_valid || (result_ready && result_last), !result_valid || result_blade == 4'd0)

endmodule

bind equivariant_multivector_linear emvl_checker u_emvl_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_blade(result.blade),
  .result_value(result.result_value),
  .result_last (result.last)
);
